// ----- hw/rtl/asm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asm_pkg: shared types and constants for the accel scale/magnitude block
// widths of the raw bytes, scaled axes, square sum and root, range codes
// ----------------------------------------------------------------------------
package asm_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned SQ_W    = 32;
  localparam int unsigned ROOT_W  = 16;
  localparam int unsigned RANGE_W = 2;
  localparam int unsigned IN_W    = 6 * BYTE_W;
  localparam int unsigned OUT_W   = 3 * AXIS_W + SQ_W + ROOT_W;

  // root bits resolved per pipeline stage of the square root
  localparam int unsigned SQRT_STEPS = 2;

  typedef enum logic [RANGE_W-1:0] {
    RANGE_2G = 2'd0,
    RANGE_4G = 2'd1,
    RANGE_8G = 2'd2
  } range_e;

  typedef struct packed {
    logic signed [AXIS_W-1:0] z;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] x;
  } axes_t;

endpackage

// ----- hw/rtl/asm_scale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asm_scale: axis decode and range scaling
// joins high/low bytes, drops the two low bits and shifts by the range
// ----------------------------------------------------------------------------
module asm_scale (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [asm_pkg::RANGE_W-1:0]  range_i,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [asm_pkg::IN_W-1:0]     data_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output asm_pkg::axes_t               axes_o
);

  logic           valid_q;
  asm_pkg::axes_t axes_d, axes_q;

  function automatic logic signed [asm_pkg::AXIS_W-1:0] scale_axis(
    input logic [asm_pkg::BYTE_W-1:0]  hi,
    input logic [asm_pkg::BYTE_W-1:0]  lo,
    input logic [asm_pkg::RANGE_W-1:0] rng
  );
    logic [asm_pkg::AXIS_W-3:0]        cnt;
    logic signed [asm_pkg::AXIS_W-1:0] res;
    cnt = {hi, lo[asm_pkg::BYTE_W-1:2]};
    unique case (asm_pkg::range_e'(rng))
      asm_pkg::RANGE_2G: res = {{2{cnt[asm_pkg::AXIS_W-3]}}, cnt};
      asm_pkg::RANGE_4G: res = {cnt[asm_pkg::AXIS_W-3], cnt, 1'b0};
      // unlisted code three behaves like 8 g
      default:           res = {cnt, 2'b00};
    endcase
    return res;
  endfunction

  always_comb begin
    axes_d.x = scale_axis(data_i[7:0],   data_i[15:8],  range_i);
    axes_d.y = scale_axis(data_i[23:16], data_i[31:24], range_i);
    axes_d.z = scale_axis(data_i[39:32], data_i[47:40], range_i);
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      axes_q <= axes_d;
    end
  end

  assign valid_o = valid_q;
  assign axes_o  = axes_q;

endmodule

// ----- hw/rtl/asm_square_sum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asm_square_sum: squares of the three axes and their sum
// two register stages: three parallel multipliers, then one 32-bit adder
// ----------------------------------------------------------------------------
module asm_square_sum (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  asm_pkg::axes_t            axes_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output asm_pkg::axes_t            axes_o,
  output logic [asm_pkg::SQ_W-1:0]  sum_o
);

  logic                            sq_valid_q, sum_valid_q;
  logic                            sq_ready, sum_ready;
  asm_pkg::axes_t                  sq_axes_q, sum_axes_q;
  logic signed [asm_pkg::SQ_W-1:0] xe, ye, ze;
  logic [asm_pkg::SQ_W-1:0]        sqx_d, sqy_d, sqz_d;
  logic [asm_pkg::SQ_W-1:0]        sqx_q, sqy_q, sqz_q;
  logic [asm_pkg::SQ_W-1:0]        sum_d, sum_q;

  // squares stay below 2^31, so the low 32 bits are exact
  assign xe    = asm_pkg::SQ_W'(axes_i.x);
  assign ye    = asm_pkg::SQ_W'(axes_i.y);
  assign ze    = asm_pkg::SQ_W'(axes_i.z);
  assign sqx_d = xe * xe;
  assign sqy_d = ye * ye;
  assign sqz_d = ze * ze;
  assign sum_d = sqx_q + sqy_q + sqz_q;

  assign sum_ready = ~sum_valid_q | ready_i;
  assign sq_ready  = ~sq_valid_q | sum_ready;
  assign ready_o   = sq_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q  <= 1'b0;
      sum_valid_q <= 1'b0;
    end else begin
      if (sq_ready) begin
        sq_valid_q <= valid_i;
      end
      if (sum_ready) begin
        sum_valid_q <= sq_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_ready && valid_i) begin
      sq_axes_q <= axes_i;
      sqx_q     <= sqx_d;
      sqy_q     <= sqy_d;
      sqz_q     <= sqz_d;
    end
    if (sum_ready && sq_valid_q) begin
      sum_axes_q <= sq_axes_q;
      sum_q      <= sum_d;
    end
  end

  assign valid_o = sum_valid_q;
  assign axes_o  = sum_axes_q;
  assign sum_o   = sum_q;

endmodule

// ----- hw/rtl/asm_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asm_sqrt: pipelined floored integer square root
// restoring digit-by-digit root, a fixed number of root bits per stage
// ----------------------------------------------------------------------------
module asm_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  asm_pkg::axes_t              axes_i,
  input  logic [asm_pkg::SQ_W-1:0]    sum_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output asm_pkg::axes_t              axes_o,
  output logic [asm_pkg::SQ_W-1:0]    sum_o,
  output logic [asm_pkg::ROOT_W-1:0]  root_o
);

  localparam int unsigned STEPS  = asm_pkg::SQRT_STEPS;
  localparam int unsigned STAGES = asm_pkg::ROOT_W / STEPS;
  localparam int unsigned REM_W  = asm_pkg::ROOT_W + 3;

  typedef struct packed {
    logic [REM_W-1:0]          rem;
    logic [asm_pkg::ROOT_W-1:0] root;
    logic [asm_pkg::SQ_W-1:0]   rad;
  } sqrt_t;

  // one root bit: bring down two radicand bits, try (root << 2) | 1
  function automatic sqrt_t sqrt_step(input sqrt_t s);
    sqrt_t            r;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    rem_sh = {s.rem[REM_W-3:0], s.rad[asm_pkg::SQ_W-1 -: 2]};
    trial  = REM_W'({s.root, 2'b01});
    r.rad  = {s.rad[asm_pkg::SQ_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      r.rem  = rem_sh - trial;
      r.root = {s.root[asm_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = rem_sh;
      r.root = {s.root[asm_pkg::ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  logic                     valid_q [STAGES];
  logic                     stage_ready [STAGES+1];
  sqrt_t                    st_q    [STAGES];
  sqrt_t                    st_d    [STAGES];
  asm_pkg::axes_t           axes_q  [STAGES];
  logic [asm_pkg::SQ_W-1:0] sum_q   [STAGES];
  logic                     src_valid [STAGES];
  sqrt_t                    src_st  [STAGES];
  asm_pkg::axes_t           src_axes [STAGES];
  logic [asm_pkg::SQ_W-1:0] src_sum [STAGES];

  assign stage_ready[STAGES] = ready_i;

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    if (k == 0) begin : g_head
      assign src_valid[k] = valid_i;
      assign src_st[k]    = '{rem: '0, root: '0, rad: sum_i};
      assign src_axes[k]  = axes_i;
      assign src_sum[k]   = sum_i;
    end else begin : g_body
      assign src_valid[k] = valid_q[k-1];
      assign src_st[k]    = st_q[k-1];
      assign src_axes[k]  = axes_q[k-1];
      assign src_sum[k]   = sum_q[k-1];
    end

    always_comb begin
      sqrt_t s;
      s = src_st[k];
      for (int unsigned j = 0; j < STEPS; j++) begin
        s = sqrt_step(s);
      end
      st_d[k] = s;
    end

    assign stage_ready[k] = ~valid_q[k] | stage_ready[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (stage_ready[k]) begin
        valid_q[k] <= src_valid[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (stage_ready[k] && src_valid[k]) begin
        st_q[k]   <= st_d[k];
        axes_q[k] <= src_axes[k];
        sum_q[k]  <= src_sum[k];
      end
    end
  end

  assign ready_o = stage_ready[0];
  assign valid_o = valid_q[STAGES-1];
  assign axes_o  = axes_q[STAGES-1];
  assign sum_o   = sum_q[STAGES-1];
  assign root_o  = st_q[STAGES-1].root;

endmodule

// ----- hw/rtl/accel_sample_scale_magnitude.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_sample_scale_magnitude: accelerometer frame scaling and magnitude
// scaled axes in 1/4096 g, their square sum and its floored square root
// ----------------------------------------------------------------------------
// usage:
//   s_axis takes one frame per transaction: six raw bytes, x high byte in
//   the lowest bits. m_axis gives one result per frame: x, y, z axes, the
//   square sum and the root, x in the lowest bits.
//   cfg_we_i writes the 2-bit range code (0: 2 g, 1: 4 g, other: 8 g); write
//   it only while no frame is in flight.
// pipeline and throughput:
//   a frame passes the registered stages in order from s_axis to m_axis
//   (scale, square, sum, then eight root stages of two bits each). One
//   frame per cycle is taken and delivered while m_axis_tready is high.
// reset:
//   range code returns to 2 g and every pipeline stage is emptied.
// stall:
//   when m_axis_tready is low the result holds; stages behind it keep filling
//   into empty slots, and s_axis_tready drops only once every stage is full.
// ----------------------------------------------------------------------------
module accel_sample_scale_magnitude (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [asm_pkg::RANGE_W-1:0]  cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // x_high, x_low, y_high, y_low, z_high, z_low
  input  logic [asm_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // accel_x, accel_y, accel_z, magnitude_squared, magnitude
  output logic [asm_pkg::OUT_W-1:0]    m_axis_tdata
);

  logic [asm_pkg::RANGE_W-1:0] range_q;
  logic                        sc_valid, sc_ready;
  asm_pkg::axes_t              sc_axes;
  logic                        ss_valid, ss_ready;
  asm_pkg::axes_t              ss_axes;
  logic [asm_pkg::SQ_W-1:0]    ss_sum;
  asm_pkg::axes_t              res_axes;
  logic [asm_pkg::SQ_W-1:0]    res_sum;
  logic [asm_pkg::ROOT_W-1:0]  res_root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= asm_pkg::RANGE_2G;
    end else if (cfg_we_i) begin
      range_q <= cfg_wdata_i;
    end
  end

  asm_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .range_i (range_q),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (s_axis_tdata),
    .valid_o (sc_valid),
    .ready_i (sc_ready),
    .axes_o  (sc_axes)
  );

  asm_square_sum u_square_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sc_valid),
    .ready_o (sc_ready),
    .axes_i  (sc_axes),
    .valid_o (ss_valid),
    .ready_i (ss_ready),
    .axes_o  (ss_axes),
    .sum_o   (ss_sum)
  );

  asm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ss_valid),
    .ready_o (ss_ready),
    .axes_i  (ss_axes),
    .sum_i   (ss_sum),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .axes_o  (res_axes),
    .sum_o   (res_sum),
    .root_o  (res_root)
  );

  assign m_axis_tdata = {res_root, res_sum, res_axes.z, res_axes.y, res_axes.x};

  // result checks
  logic [asm_pkg::SQ_W:0]          root_sq, root_next_sq;
  logic signed [asm_pkg::SQ_W-1:0] chk_x, chk_y, chk_z;
  logic [asm_pkg::SQ_W-1:0]        chk_sum;

  assign root_sq      = (asm_pkg::SQ_W+1)'(res_root) * (asm_pkg::SQ_W+1)'(res_root);
  assign root_next_sq = ((asm_pkg::SQ_W+1)'(res_root) + 1'b1)
                      * ((asm_pkg::SQ_W+1)'(res_root) + 1'b1);
  assign chk_x   = asm_pkg::SQ_W'(res_axes.x);
  assign chk_y   = asm_pkg::SQ_W'(res_axes.y);
  assign chk_z   = asm_pkg::SQ_W'(res_axes.z);
  assign chk_sum = chk_x * chk_x + chk_y * chk_y + chk_z * chk_z;

  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (root_sq <= (asm_pkg::SQ_W+1)'(res_sum))
                   && (root_next_sq > (asm_pkg::SQ_W+1)'(res_sum)))
    else $error("magnitude is not the floored root of magnitude_squared");

  a_sum_matches_axes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> chk_sum == res_sum)
    else $error("magnitude_squared does not match the delivered axes");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the output stage is empty");

  a_range_reset: assert property (@(posedge clk_i)
    !rst_ni |=> range_q == asm_pkg::RANGE_2G || $past(cfg_we_i))
    else $error("range code not cleared by reset");

endmodule
